// File: rtl/replay_nonce_window_filter_defines.svh
// Assertion macros shared by the replay nonce window filter RTL.
`ifndef REPLAY_NONCE_WINDOW_FILTER_DEFINES_SVH
`define REPLAY_NONCE_WINDOW_FILTER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define RNWF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define RNWF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define RNWF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rnwf_pkg.sv
// Types and constants shared by the replay nonce window filter modules.
package rnwf_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SKEW    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'd1;

  localparam logic [31:0] MAX_SKEW_RESET    = 32'd30000;
  localparam logic [6:0]  MAX_ENTRIES_RESET = 7'd64;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_STALE  = 2'd1,
    VERDICT_REPLAY = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [63:0]        nonce_value;
    logic signed [63:0] message_time;
    logic signed [63:0] current_time;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] verdict_code;
    logic [6:0] stored_count;
  } out_t;

  // Word handed from the front end to the store engine.
  typedef struct packed {
    logic [63:0] nonce;
    logic        stale;
  } cls_t;

endpackage

// File: rtl/replay_nonce_window_filter.sv
// Top level of the replay nonce window filter: configuration, front end, queue, store engine.
//
// Each input word is first checked against the time window in the front end (one register
// stage), then handed through a two-entry queue to the store engine. The engine reads the
// nonce ring one entry a cycle through a single memory port. A fresh word is compared with
// every nonce held; a hit ends the scan early. A stale word skips the scan. The engine waits
// while the output register still holds an unaccepted result. The ring needs no clearing
// after reset, since only entries written since reset are ever read. Results wait in an
// output register, and the front end keeps taking words while it waits, until the queue
// and the front-end register are full.
module replay_nonce_window_filter #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  rnwf_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rnwf_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [rnwf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rnwf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic [31:0] max_skew_q;
  logic [6:0]  max_entries_q;

  logic           fr_valid, fr_ready, bk_valid, bk_ready;
  rnwf_pkg::cls_t fr_word, bk_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_skew_q    <= rnwf_pkg::MAX_SKEW_RESET;
      max_entries_q <= rnwf_pkg::MAX_ENTRIES_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rnwf_pkg::CFG_MAX_SKEW:    max_skew_q    <= cfg_data_i[31:0];
        rnwf_pkg::CFG_MAX_ENTRIES: max_entries_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  rnwf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_data_i),
    .in_ready_o  (in_ready_o),
    .max_skew_i  (max_skew_q),
    .cls_valid_o (fr_valid),
    .cls_o       (fr_word),
    .cls_ready_i (fr_ready)
  );

  rnwf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_i       (fr_word),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_o        (bk_word),
    .pop_ready_i  (bk_ready)
  );

  rnwf_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cls_valid_i   (bk_valid),
    .cls_i         (bk_word),
    .cls_ready_o   (bk_ready),
    .max_entries_i (max_entries_q),
    .out_valid_o   (out_valid_o),
    .out_o         (out_data_o),
    .out_ready_i   (out_ready_i)
  );

endmodule

// File: rtl/rnwf_front.sv
// Front end: accepts input words and classifies them against the time window.
module rnwf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  rnwf_pkg::in_t       in_i,
  output logic                in_ready_o,
  input  logic [31:0]         max_skew_i,
  output logic                cls_valid_o,
  output rnwf_pkg::cls_t      cls_o,
  input  logic                cls_ready_i
);

  logic               stg_valid_q, stg_valid_d;
  logic [63:0]        stg_nonce_q;
  logic signed [64:0] diff_q, diff_d;
  logic signed [64:0] skew_pos, skew_neg;
  logic               in_fire;

  assign in_ready_o = !stg_valid_q || cls_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // The difference is taken one bit wider than the operands, so it is exact.
  assign diff_d = {in_i.current_time[63], in_i.current_time}
                - {in_i.message_time[63], in_i.message_time};

  assign skew_pos = $signed({33'd0, max_skew_i});
  assign skew_neg = -skew_pos;

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_fire) begin
      stg_valid_d = 1'b1;
    end else if (cls_ready_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      stg_nonce_q <= in_i.nonce_value;
      diff_q      <= diff_d;
    end
  end

  assign cls_valid_o = stg_valid_q;
  assign cls_o.nonce = stg_nonce_q;
  assign cls_o.stale = (diff_q > skew_pos) || (diff_q < skew_neg);

endmodule

// File: rtl/rnwf_queue.sv
// Two-entry queue that decouples the front end from the store engine.
module rnwf_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  rnwf_pkg::cls_t push_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output rnwf_pkg::cls_t pop_o,
  input  logic           pop_ready_i
);

  rnwf_pkg::cls_t slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

// File: rtl/rnwf_back.sv
// Store engine: scans the nonce ring for a replay, then appends and evicts.
`include "replay_nonce_window_filter_defines.svh"

module rnwf_back #(
  parameter int STORE_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cls_valid_i,
  input  rnwf_pkg::cls_t cls_i,
  output logic           cls_ready_o,
  input  logic [6:0]     max_entries_i,
  output logic           out_valid_o,
  output rnwf_pkg::out_t out_o,
  input  logic           out_ready_i
);

  localparam int PTR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  logic [63:0] mem [STORE_DEPTH];

  rnwf_pkg::back_state_e state_q, state_d;
  rnwf_pkg::verdict_e    verdict_q;
  logic [63:0]           nonce_q;
  logic [63:0]           rdata_q;
  logic [PTR_W-1:0]      scan_q, oldest_q, scan_inc, oldest_inc;
  logic [CNT_W-1:0]      count_q, idx_q, count_new, limit;
  logic                  pend_q;
  logic                  out_valid_q;
  rnwf_pkg::out_t        out_q;

  logic        out_free, hit, issue, commit, mem_we, evict, scan_end, pop;
  logic [31:0] ent32, lim32, count_ext;

  assign out_free = !out_valid_q || out_ready_i;
  assign hit      = pend_q && (rdata_q == nonce_q);
  assign scan_end = hit || (!issue && !pend_q);

  assign scan_inc   = (scan_q == PTR_W'(STORE_DEPTH - 1)) ? '0 : scan_q + PTR_W'(1);
  assign oldest_inc = (oldest_q == PTR_W'(STORE_DEPTH - 1)) ? '0 : oldest_q + PTR_W'(1);

  // A limit of zero counts as one, and any limit beyond the ring counts as the ring.
  assign ent32 = 32'(max_entries_i);
  always_comb begin
    lim32 = ent32;
    if (ent32 == 32'd0) begin
      lim32 = 32'd1;
    end else if (ent32 > 32'(STORE_DEPTH)) begin
      lim32 = 32'(STORE_DEPTH);
    end
  end
  assign limit = lim32[CNT_W-1:0];
  assign evict = (count_q >= limit);

  always_comb begin
    count_new = count_q;
    if (verdict_q == rnwf_pkg::VERDICT_OK && !evict) begin
      count_new = count_q + CNT_W'(1);
    end
  end
  assign count_ext = 32'(count_new);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rnwf_pkg::BK_IDLE: begin
        if (cls_valid_i) begin
          state_d = cls_i.stale ? rnwf_pkg::BK_DONE : rnwf_pkg::BK_SCAN;
        end
      end
      rnwf_pkg::BK_SCAN: begin
        if (scan_end) begin
          state_d = rnwf_pkg::BK_DONE;
        end
      end
      rnwf_pkg::BK_DONE: begin
        if (out_free) begin
          state_d = rnwf_pkg::BK_IDLE;
        end
      end
      default: state_d = rnwf_pkg::BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cls_ready_o = 1'b0;
    issue       = 1'b0;
    commit      = 1'b0;
    case (state_q)
      rnwf_pkg::BK_IDLE: cls_ready_o = 1'b1;
      rnwf_pkg::BK_SCAN: issue = (idx_q != count_q) && !hit;
      rnwf_pkg::BK_DONE: commit = out_free;
      default: ;
    endcase
  end

  assign pop    = cls_valid_i && cls_ready_o;
  assign mem_we = commit && (verdict_q == rnwf_pkg::VERDICT_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rnwf_pkg::BK_IDLE;
      count_q     <= '0;
      oldest_q    <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= issue;
      if (pop) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (mem_we) begin
        count_q <= count_new;
        if (evict) begin
          oldest_q <= oldest_inc;
        end
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // After a scan without a hit, the scan pointer sits on the free slot.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[scan_q];
    if (mem_we) begin
      mem[scan_q] <= nonce_q;
    end
    if (pop) begin
      nonce_q   <= cls_i.nonce;
      verdict_q <= cls_i.stale ? rnwf_pkg::VERDICT_STALE : rnwf_pkg::VERDICT_OK;
      scan_q    <= oldest_q;
    end else if (issue) begin
      scan_q <= scan_inc;
    end
    if (state_q == rnwf_pkg::BK_SCAN && scan_end) begin
      verdict_q <= hit ? rnwf_pkg::VERDICT_REPLAY : rnwf_pkg::VERDICT_OK;
    end
    if (commit) begin
      out_q.accepted     <= (verdict_q == rnwf_pkg::VERDICT_OK);
      out_q.verdict_code <= verdict_q;
      out_q.stored_count <= count_ext[6:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `RNWF_ASSERT_ALWAYS(a_count_in_ring, count_q <= CNT_W'(STORE_DEPTH), "entry count beyond ring")
  `RNWF_ASSERT_IMP(a_scan_bounded, state_q == rnwf_pkg::BK_SCAN, idx_q <= count_q, "scan overran count")
  `RNWF_ASSERT_NEXT(a_append_nonempty, mem_we, count_q != '0, "store empty after an append")
  `RNWF_ASSERT_IMP(a_stale_no_write, mem_we, verdict_q != rnwf_pkg::VERDICT_STALE, "stale word written")

endmodule

// File: sim/nonce_filter_checker.sv
// Checker that predicts the filter's verdict for every accepted word and compares the results.
module nonce_filter_checker #(
  parameter int STORE_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  rnwf_pkg::in_t                   in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  rnwf_pkg::out_t                  out_data_i,
  input  logic                            cfg_we_i,
  input  logic [rnwf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rnwf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fail_count_o,
  output int                              due_count_o,
  output int                              checked_o
);

  localparam int DUE_DEPTH = 16;

  logic [63:0]    seen_nonces [STORE_DEPTH];
  int             oldest_slot = 0;
  int             held = 0;
  logic [31:0]    skew_limit = rnwf_pkg::MAX_SKEW_RESET;
  logic [6:0]     entry_limit = rnwf_pkg::MAX_ENTRIES_RESET;
  rnwf_pkg::out_t verdicts_due [DUE_DEPTH];
  int             due_wr = 0;
  int             due_rd = 0;
  rnwf_pkg::out_t want;
  int             fails = 0;
  int             checked = 0;

  // Works out the verdict for one word and updates the model of the store.
  task automatic judge_word(input rnwf_pkg::in_t w);
    logic signed [64:0] gap;
    rnwf_pkg::out_t     v;
    logic               hit;
    int                 cap;
    // The gap is taken at 65 bits, so even the widest spread of times cannot wrap.
    gap = $signed({w.current_time[63], w.current_time})
        - $signed({w.message_time[63], w.message_time});
    if (gap < 0) gap = -gap;
    hit = 1'b0;
    for (int i = 0; i < held; i++) begin
      if (seen_nonces[(oldest_slot + i) % STORE_DEPTH] == w.nonce_value) hit = 1'b1;
    end
    v = '0;
    // A stale word is reported as stale even when its nonce is also held.
    if (gap > $signed({33'd0, skew_limit})) begin
      v.verdict_code = rnwf_pkg::VERDICT_STALE;
    end else if (hit) begin
      v.verdict_code = rnwf_pkg::VERDICT_REPLAY;
    end else begin
      cap = (entry_limit == 7'd0) ? 1 :
            (int'(entry_limit) > STORE_DEPTH) ? STORE_DEPTH : int'(entry_limit);
      // Only one nonce leaves per accepted word, even if the limit was lowered a lot.
      if (held >= cap && held > 0) begin
        oldest_slot = (oldest_slot + 1) % STORE_DEPTH;
        held--;
      end
      seen_nonces[(oldest_slot + held) % STORE_DEPTH] = w.nonce_value;
      held++;
      v.verdict_code = rnwf_pkg::VERDICT_OK;
      v.accepted = 1'b1;
    end
    v.stored_count = held[6:0];
    if (due_wr - due_rd >= DUE_DEPTH) begin
      $display("%0t: more results outstanding than the checker can hold: expected at most %0d, actual %0d",
               $time, DUE_DEPTH - 1, due_wr - due_rd);
      fails++;
    end
    verdicts_due[due_wr % DUE_DEPTH] = v;
    due_wr++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_slot = 0;
      held = 0;
      skew_limit = rnwf_pkg::MAX_SKEW_RESET;
      entry_limit = rnwf_pkg::MAX_ENTRIES_RESET;
      due_wr = 0;
      due_rd = 0;
    end else begin
      // A result leaving at this edge can never belong to a word entering at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (due_wr == due_rd) begin
          $display("%0t: result with none expected: accepted=%0d verdict=%0d count=%0d",
                   $time, out_data_i.accepted, out_data_i.verdict_code,
                   out_data_i.stored_count);
          fails++;
        end else begin
          want = verdicts_due[due_rd % DUE_DEPTH];
          due_rd++;
          checked++;
          if (out_data_i.accepted !== want.accepted ||
              out_data_i.verdict_code !== want.verdict_code ||
              out_data_i.stored_count !== want.stored_count) begin
            $display("%0t: mismatch: expected accepted=%0d verdict=%0d count=%0d, %s%0d %s%0d %s%0d",
                     $time, want.accepted, want.verdict_code, want.stored_count,
                     "actual accepted=", out_data_i.accepted,
                     "verdict=", out_data_i.verdict_code,
                     "count=", out_data_i.stored_count);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) judge_word(in_data_i);
      if (cfg_we_i) begin
        case (cfg_index_i)
          rnwf_pkg::CFG_MAX_SKEW:    skew_limit = cfg_data_i;
          rnwf_pkg::CFG_MAX_ENTRIES: entry_limit = cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    due_count_o  <= due_wr - due_rd;
    checked_o    <= checked;
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: drives words, stalls and register settings into the filter and gives the verdict.
module tb_top;

  localparam int          STORE_DEPTH = 64;
  localparam int          HOLD_OFF    = 300;
  localparam int          STALL_LIMIT = 4000;
  localparam int          PHASES      = 12;
  localparam int          PHASE_WORDS = 75;
  localparam int          RECENT      = 80;
  localparam logic [63:0] TIME_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TIME_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] BASE_T      = 64'd1_000_000;

  typedef enum int {W_FRESH, W_REPLAY, W_STALE, W_BORDER, W_NOISE} word_kind_e;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  rnwf_pkg::in_t                   in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  rnwf_pkg::out_t                  out_data;
  logic                            cfg_we = 1'b0;
  logic [rnwf_pkg::CFG_IDX_W-1:0]  cfg_index = rnwf_pkg::CFG_MAX_SKEW;
  logic [rnwf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int          fail_count;
  int          due_count;
  int          checked_count;
  int          hold_asks = 0;
  int          words_sent = 0;
  bit          quiet = 1'b0;
  logic [31:0] skew_now = rnwf_pkg::MAX_SKEW_RESET;
  logic [63:0] recent_nonces [RECENT];
  int          recent_fill = 0;
  int          recent_wr = 0;

  always #1 clk = ~clk;

  replay_nonce_window_filter #(.STORE_DEPTH(STORE_DEPTH)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  nonce_filter_checker #(.STORE_DEPTH(STORE_DEPTH)) verdict_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .due_count_o  (due_count),
    .checked_o    (checked_count)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [63:0] pick_time();
    logic [31:0] s;
    s = $urandom;
    case ($urandom_range(3, 0))
      0:       return rand64();
      1:       return {{32{s[31]}}, s};
      2:       return TIME_MAX - s;
      default: return TIME_MIN + s;
    endcase
  endfunction

  function automatic rnwf_pkg::in_t build_word(input word_kind_e kind);
    rnwf_pkg::in_t w;
    logic [63:0]   cur;
    logic [63:0]   delta;
    cur = pick_time();
    w.nonce_value = rand64();
    delta = 64'($urandom_range(skew_now, 0));
    case (kind)
      W_REPLAY: begin
        if (recent_fill > 0)
          w.nonce_value = recent_nonces[$urandom_range(recent_fill - 1, 0)];
      end
      W_STALE: begin
        delta = {32'd0, skew_now} + 64'd1 + $urandom_range(5000, 0);
        if ($urandom_range(1, 0) && recent_fill > 0)
          w.nonce_value = recent_nonces[$urandom_range(recent_fill - 1, 0)];
      end
      W_BORDER: delta = {32'd0, skew_now} + $urandom_range(1, 0);
      W_NOISE: begin
        cur = rand64();
        delta = rand64();
      end
      default: ;
    endcase
    w.current_time = cur;
    w.message_time = $urandom_range(1, 0) ? cur - delta : cur + delta;
    return w;
  endfunction

  // Holds the word on the bus until the filter takes it; returns at the accepting edge.
  task automatic offer_word(input rnwf_pkg::in_t w);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] skew, input logic [6:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= rnwf_pkg::CFG_MAX_SKEW;
    cfg_data  <= skew;
    @(posedge clk);
    cfg_index <= rnwf_pkg::CFG_MAX_ENTRIES;
    cfg_data  <= {25'd0, lim};
    @(posedge clk);
    cfg_we <= 1'b0;
    skew_now = skew;
  endtask

  initial begin : stimulus
    logic [31:0]   skew;
    logic [6:0]    lim;
    int            r;
    rnwf_pkg::in_t w;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a window of 30000 ms and a full-depth store.
    offer_word(rnwf_pkg::in_t'{64'd0, 64'd0, 64'd0});
    offer_word(rnwf_pkg::in_t'{'1, TIME_MAX, TIME_MAX});
    offer_word(rnwf_pkg::in_t'{64'd0, 64'd5, 64'd5});
    offer_word(rnwf_pkg::in_t'{64'h0102_0304_0506_0708, TIME_MIN, TIME_MAX});
    offer_word(rnwf_pkg::in_t'{64'h0102_0304_0506_0708, TIME_MAX, TIME_MIN});
    offer_word(rnwf_pkg::in_t'{64'h0102_0304_0506_0708, TIME_MIN, TIME_MIN});
    offer_word(rnwf_pkg::in_t'{64'hA5A5_0000_0000_0001, BASE_T - 64'd30000, BASE_T});
    offer_word(rnwf_pkg::in_t'{64'h5A5A_0000_0000_0002, BASE_T - 64'd30001, BASE_T});
    offer_word(rnwf_pkg::in_t'{64'h5A5A_0000_0000_0002, BASE_T + 64'd30000, BASE_T});
    offer_word(rnwf_pkg::in_t'{64'hC3C3_0000_0000_0003, BASE_T + 64'd30001, BASE_T});
    // The window is crossed through zero here.
    offer_word(rnwf_pkg::in_t'{64'h3C3C_0000_0000_0004, 64'd29995, 64'hFFFF_FFFF_FFFF_FFFB});
    offer_word(rnwf_pkg::in_t'{64'd0, BASE_T + 64'd40000, BASE_T});
    offer_word(rnwf_pkg::in_t'{'1, 64'd0, '1});
    wait_drained();

    // A zero window and a limit of one, set below what the store already holds.
    set_config(32'd0, 7'd1);
    offer_word(rnwf_pkg::in_t'{64'hE000_0000_0000_0005, BASE_T, BASE_T});
    offer_word(rnwf_pkg::in_t'{64'hF000_0000_0000_0006, BASE_T + 64'd1, BASE_T});
    wait_drained();

    // The widest window, with a limit of zero.
    set_config(32'hFFFF_FFFF, 7'd0);
    offer_word(rnwf_pkg::in_t'{64'h1111_0000_0000_0007, 64'hFFFF_FFFF_0000_0001, 64'd0});
    offer_word(rnwf_pkg::in_t'{64'h2222_0000_0000_0008, 64'hFFFF_FFFF_0000_0000, 64'd0});
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin skew = 32'd1000; lim = 7'd4; end
        1: begin skew = 32'd0; lim = 7'd1; end
        2: begin skew = 32'hFFFF_FFFF; lim = 7'd64; end
        3: begin skew = $urandom; lim = 7'd0; end
        4: begin skew = 32'd50; lim = 7'd127; end
        5: begin skew = $urandom_range(100000, 1); lim = 7'd3; end
        6: begin skew = $urandom_range(20000, 0); lim = 7'd65; end
        default: begin
          skew = $urandom_range(1, 0) ? $urandom : $urandom_range(5000, 0);
          lim = 7'($urandom_range(127, 0));
        end
      endcase
      set_config(skew, lim);
      quiet = (p % 4 == 3);
      // Here the receiver stops for a long while, so the filter fills up and holds its input.
      if (p == 2) hold_asks <= hold_asks + 1;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        r = $urandom_range(99, 0);
        w = build_word(r < 45 ? W_FRESH : r < 70 ? W_REPLAY : r < 83 ? W_STALE :
                       r < 92 ? W_BORDER : W_NOISE);
        offer_word(w);
        recent_nonces[recent_wr] = w.nonce_value;
        recent_wr = (recent_wr + 1) % RECENT;
        if (recent_fill < RECENT) recent_fill++;
      end
      wait_drained();
    end

    repeat (2 * STORE_DEPTH) @(posedge clk);
    $display("Run covered %0d words over %0d register settings, with a %0d-cycle output hold-off.",
             words_sent, PHASES + 2, HOLD_OFF);
    $display("%0d verdicts compared; windows from 0 to 2^32-1 ms, limits from 0 to 127.",
             checked_count);
    if (fail_count == 0 && due_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : drain
    int hold_seen;
    int n;
    hold_seen = 0;
    @(posedge clk);
    forever begin
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        n = HOLD_OFF;
      end else begin
        n = idle_len();
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (($urandom_range(7, 0) == 0) ? 60 : $urandom_range(6, 1)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int still_cycles;
    still_cycles = 0;
    while (still_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) still_cycles = 0;
      else still_cycles++;
    end
    $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
